[rtl/olist_pkg.sv]
// Package for the ordered list unit: sizes, operation and status codes,
// and the control bundle broadcast to the entry cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

	localparam int CAPACITY  = 16;
	localparam int ITEM_BITS = 32;

	localparam int FUNC_W   = 3;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = $clog2(CAPACITY);

	localparam int IN_BITS  = FUNC_W + POS_W + ITEM_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STATUS_W + POS_W + ITEM_BITS + POS_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND  = 3'd0,
		FN_INSERT  = 3'd1,
		FN_REPLACE = 3'd2,
		FN_REMOVE  = 3'd3,
		FN_READ    = 3'd4,
		FN_FIND    = 3'd5,
		FN_SIZE    = 3'd6
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef logic [ITEM_BITS-1:0] item_t;

	// Broadcast to every cell; enables are already qualified by the transfer
	typedef struct packed {
		logic             ins_en;
		logic             rem_en;
		logic             rep_en;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] count;
		item_t            word;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/ordered_list_insert_remove_search_unit.sv]
// Top level of the ordered list unit: request decode, status, the row of
// entry cells, first-hit search and the result register.
// Depends on olist_pkg and olist_cell.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                       Carries
// request   in   s_tvalid/s_tready/s_tdata   func, position, item_value
// result    out  m_tvalid/m_tready/m_tdata   status, index, old_value, entry_count_out
//
// One request per cycle while no result is stalled: each request is decoded,
// checked and applied to the row of entry cells in the cycle of its transfer,
// and its result sits in the output register from the next cycle on. The cells
// shift their neighbor in the same update, so insert and remove cost the same as read.
// Reset clears the entry count and the output valid; entry words need none.
// A stalled result holds; a new request is taken in the same cycle the held
// result leaves.

module ordered_list_insert_remove_search_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// [2:0] func, [7:3] position, [39:8] item_value
	input  wire logic [olist_pkg::IN_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// [1:0] status, [6:2] index, [38:7] old_value, [43:39] entry_count_out,
	// upper bits zero
	output logic [olist_pkg::OUT_W-1:0]      m_tdata
);
	import olist_pkg::*;

	// request fields
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  position;
	item_t             item_value;

	// control and state
	logic              accept;
	logic [POS_W-1:0]  entry_count_q;
	logic              m_tvalid_q;

	// cell row
	cell_ctrl_t        ctrl;
	item_t             cell_value [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;

	// decode results
	logic              found;
	logic [POS_W-1:0]  found_idx;
	item_t             pos_value;
	logic              full;
	logic              pos_in_list;
	logic              ins_ok;
	logic              rem_ok;
	logic              rep_ok;
	status_t           nxt_status;
	logic [POS_W-1:0]  nxt_index;
	item_t             nxt_old;
	logic [POS_W-1:0]  nxt_count;

	// result register
	status_t           status_q;
	logic [POS_W-1:0]  index_q;
	item_t             old_value_q;
	logic [POS_W-1:0]  count_out_q;

	assign func       = s_tdata[FUNC_W-1:0];
	assign position   = s_tdata[FUNC_W +: POS_W];
	assign item_value = s_tdata[FUNC_W+POS_W +: ITEM_BITS];

	// take a new request whenever the result slot is empty or draining
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full        = (entry_count_q >= POS_W'(CAPACITY));
	assign pos_in_list = (position < entry_count_q);
	// word at the requested slot; only used when the position is in the list
	assign pos_value   = cell_value[position[SLOT_W-1:0]];

	// first hit wins: scan from the top so the lowest slot overwrites last
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_hit[i]) begin
				found     = 1'b1;
				found_idx = POS_W'(i);
			end
		end
	end

	// decode the request: status, result fields, and which cell action to take
	always_comb begin
		nxt_status = ST_OK;
		nxt_index  = '0;
		nxt_old    = '0;
		nxt_count  = entry_count_q;
		ins_ok     = 1'b0;
		rem_ok     = 1'b0;
		rep_ok     = 1'b0;
		ctrl.pos   = position;
		unique case (func)
			FN_APPEND: begin
				// append is an insert at the current count
				ctrl.pos = entry_count_q;
				if (full) begin
					nxt_status = ST_FULL;
				end else begin
					ins_ok    = 1'b1;
					nxt_index = entry_count_q;
					nxt_count = entry_count_q + POS_W'(1);
				end
			end
			FN_INSERT: begin
				if (position > entry_count_q) begin
					nxt_status = ST_BADPOS;
				end else if (full) begin
					nxt_status = ST_FULL;
				end else begin
					ins_ok    = 1'b1;
					nxt_index = position;
					nxt_count = entry_count_q + POS_W'(1);
				end
			end
			FN_REPLACE: begin
				if (!pos_in_list) begin
					nxt_status = ST_BADPOS;
				end else begin
					rep_ok  = 1'b1;
					nxt_old = pos_value;
				end
			end
			FN_REMOVE: begin
				if (!pos_in_list) begin
					nxt_status = ST_BADPOS;
				end else begin
					rem_ok    = 1'b1;
					nxt_old   = pos_value;
					nxt_count = entry_count_q - POS_W'(1);
				end
			end
			FN_READ: begin
				if (!pos_in_list) begin
					nxt_status = ST_BADPOS;
				end else begin
					nxt_old = pos_value;
				end
			end
			FN_FIND: begin
				if (found) begin
					nxt_index = found_idx;
				end else begin
					nxt_status = ST_NOTFOUND;
				end
			end
			default: begin
				// size, and the unused code, report the count and change nothing
				nxt_status = ST_OK;
			end
		endcase
		ctrl.ins_en = accept && ins_ok;
		ctrl.rem_en = accept && rem_ok;
		ctrl.rep_en = accept && rep_ok;
		ctrl.count  = entry_count_q;
		ctrl.word   = item_value;
	end

	// row of entry cells; the ends see zero beyond the row
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		item_t left_v;
		item_t right_v;
		if (g == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_inner_l
			assign left_v = cell_value[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_inner_r
			assign right_v = cell_value[g+1];
		end
		olist_cell u_cell (
			.clk         (clk),
			.slot_idx    (POS_W'(g)),
			.ctrl        (ctrl),
			.left_value  (left_v),
			.right_value (right_v),
			.value       (cell_value[g]),
			.hit         (cell_hit[g])
		);
	end

	// entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (accept) begin
				entry_count_q <= nxt_count;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload; hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= nxt_status;
			index_q     <= nxt_index;
			old_value_q <= nxt_old;
			count_out_q <= nxt_count;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_W - OUT_BITS)'(0), count_out_q, old_value_q, index_q, status_q};

endmodule

`default_nettype wire

[rtl/olist_cell.sv]
// One entry cell of the ordered list: holds a word, takes its left or right
// neighbor on a shift, loads the request word, and flags a search hit.
// Depends on olist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olist_cell (
	input  wire logic                      clk,
	input  wire logic [olist_pkg::POS_W-1:0] slot_idx,
	input  wire olist_pkg::cell_ctrl_t     ctrl,
	input  wire olist_pkg::item_t          left_value,
	input  wire olist_pkg::item_t          right_value,
	output olist_pkg::item_t               value,
	output logic                           hit
);
	import olist_pkg::*;

	item_t            value_q;
	logic [POS_W:0]   idx_plus1;

	assign idx_plus1 = {1'b0, slot_idx} + (POS_W+1)'(1);

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (slot_idx == ctrl.pos) begin
				value_q <= ctrl.word;
			end else if (slot_idx > ctrl.pos && slot_idx <= ctrl.count) begin
				value_q <= left_value;
			end
		end else if (ctrl.rem_en) begin
			// close the gap: each cell from the removed slot to the second-last entry takes its right
			if (slot_idx >= ctrl.pos && idx_plus1 < {1'b0, ctrl.count}) begin
				value_q <= right_value;
			end
		end else if (ctrl.rep_en) begin
			if (slot_idx == ctrl.pos) begin
				value_q <= ctrl.word;
			end
		end
	end

	assign value = value_q;
	assign hit   = (value_q == ctrl.word) && (slot_idx < ctrl.count);

endmodule

`default_nettype wire
